// ----- rtl/cdb_pkg.sv -----
// shared codes and field widths for the circular deque buffer
package cdb_pkg;

    // field widths fixed by the request and result formats
    localparam int REQ_W = 4;
    localparam int POS_W = 6;
    localparam int CNT_W = 7;
    localparam int ST_W  = 2;

    typedef logic [REQ_W-1:0] t_req;
    typedef logic [ST_W-1:0]  t_status;
    typedef logic [CNT_W-1:0] t_count;
    typedef logic [POS_W-1:0] t_pos;

    // request codes
    localparam t_req REQ_CLEAR      = 4'd0;
    localparam t_req REQ_PUSH_BACK  = 4'd1;
    localparam t_req REQ_PUSH_FRONT = 4'd2;
    localparam t_req REQ_PUSH_OVR   = 4'd3;
    localparam t_req REQ_POP_FRONT  = 4'd4;
    localparam t_req REQ_POP_BACK   = 4'd5;
    localparam t_req REQ_PEEK_FRONT = 4'd6;
    localparam t_req REQ_PEEK_BACK  = 4'd7;
    localparam t_req REQ_READ_IDX   = 4'd8;

    // result status codes
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;
    localparam t_status ST_RANGE = 2'd3;

endpackage

// ----- rtl/circular_deque_buffer.sv -----
// double-ended ring buffer over a slot memory with a configurable capacity
// a result is registered and appears in the cycle after its request is accepted
// throughput: one request per cycle while results are taken; the single registered memory read port sets this
// s_axis_tready drops only while a finished result waits on m_axis_tready
// reset (synchronous, active low): pointers and count cleared, capacity set to min(64, DEPTH)
// the slot memory is not cleared; a held entry is always written before it is read
module circular_deque_buffer #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration: capacity_in_use
    input  logic                          i_cfg_we,
    input  cdb_pkg::t_count               i_cfg_data,
    // request stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata: data_in, position
    input  logic [((DATA_WIDTH+cdb_pkg::POS_W+7)/8)*8-1:0] s_axis_tdata,
    // tuser: req_type
    input  cdb_pkg::t_req                 s_axis_tuser,
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata: read_data, fill_count, space_left, is_empty, is_full
    output logic [((DATA_WIDTH+2*cdb_pkg::CNT_W+2+7)/8)*8-1:0] m_axis_tdata,
    // tuser: status
    output cdb_pkg::t_status              m_axis_tuser
);
    import cdb_pkg::*;

    localparam int PW          = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ADD_W       = ((PW > CNT_W) ? PW : CNT_W) + 1;
    localparam int OUT_TDATA_W = ((DATA_WIDTH + 2*CNT_W + 2 + 7) / 8) * 8;
    localparam int CAP_RST     = (DEPTH < 64) ? DEPTH : 64;

    // ring state
    logic [PW-1:0]         r_front, n_front;
    logic [PW-1:0]         r_back, n_back;
    t_count                r_held, n_held;
    t_count                r_cap;

    // slot memory and its read register
    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    // result register
    logic                  r_out_valid;
    logic                  r_has_data;
    t_status               r_status;
    t_count                r_fill;
    t_count                r_free;
    logic                  r_empty;
    logic                  r_full;

    // request decode
    logic                  s_accept;
    logic [DATA_WIDTH-1:0] req_data;
    t_pos                  req_pos;
    logic                  ring_full, ring_empty;
    logic [PW-1:0]         front_up, front_dn, back_up, back_dn;
    logic [ADD_W-1:0]      idx_sum;
    logic [PW-1:0]         idx_slot;
    logic                  wr_en, rd_en;
    logic [PW-1:0]         wr_addr, rd_addr;
    t_status               n_status;
    t_count                cfg_cap;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign req_data      = s_axis_tdata[DATA_WIDTH-1:0];
    assign req_pos       = s_axis_tdata[DATA_WIDTH +: POS_W];

    assign ring_full  = (r_held >= r_cap);
    assign ring_empty = (r_held == '0);

    // pointer steps with wrap at the capacity
    assign front_up = ((ADD_W'(r_front) + ADD_W'(1)) >= ADD_W'(r_cap))
                    ? '0 : PW'(ADD_W'(r_front) + ADD_W'(1));
    assign back_up  = ((ADD_W'(r_back) + ADD_W'(1)) >= ADD_W'(r_cap))
                    ? '0 : PW'(ADD_W'(r_back) + ADD_W'(1));
    assign front_dn = (r_front == '0) ? PW'(ADD_W'(r_cap) - ADD_W'(1)) : r_front - PW'(1);
    assign back_dn  = (r_back == '0) ? PW'(ADD_W'(r_cap) - ADD_W'(1)) : r_back - PW'(1);

    // logical index to slot, one conditional subtract of the capacity
    assign idx_sum  = ADD_W'(r_front) + ADD_W'(req_pos);
    assign idx_slot = (idx_sum >= ADD_W'(r_cap)) ? PW'(idx_sum - ADD_W'(r_cap))
                                                 : PW'(idx_sum);

    // capacity written out of range is clamped to 1..DEPTH
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_cap = CNT_W'(1);
        end else if (32'(i_cfg_data) > 32'(DEPTH)) begin
            cfg_cap = CNT_W'(DEPTH);
        end else begin
            cfg_cap = i_cfg_data;
        end
    end

    // per-request next state, memory access and status
    always_comb begin
        n_front  = r_front;
        n_back   = r_back;
        n_held   = r_held;
        n_status = ST_OK;
        wr_en    = 1'b0;
        wr_addr  = r_back;
        rd_en    = 1'b0;
        rd_addr  = r_front;
        case (s_axis_tuser)
            REQ_CLEAR: begin
                n_front = '0;
                n_back  = '0;
                n_held  = '0;
            end
            REQ_PUSH_BACK: begin
                if (ring_full) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en  = 1'b1;
                    n_back = back_up;
                    n_held = r_held + CNT_W'(1);
                end
            end
            REQ_PUSH_FRONT: begin
                if (ring_full) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = front_dn;
                    n_front = front_dn;
                    n_held  = r_held + CNT_W'(1);
                end
            end
            REQ_PUSH_OVR: begin
                wr_en  = 1'b1;
                n_back = back_up;
                if (ring_full) begin
                    // drop the oldest entry, count stays at capacity
                    n_status = ST_FULL;
                    n_front  = front_up;
                end else begin
                    n_held = r_held + CNT_W'(1);
                end
            end
            REQ_POP_FRONT: begin
                if (ring_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    rd_en   = 1'b1;
                    n_front = front_up;
                    n_held  = r_held - CNT_W'(1);
                end
            end
            REQ_POP_BACK: begin
                if (ring_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = back_dn;
                    n_back  = back_dn;
                    n_held  = r_held - CNT_W'(1);
                end
            end
            REQ_PEEK_FRONT: begin
                if (ring_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    rd_en = 1'b1;
                end
            end
            REQ_PEEK_BACK: begin
                if (ring_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = back_dn;
                end
            end
            REQ_READ_IDX: begin
                if (CNT_W'(req_pos) >= r_held) begin
                    n_status = ST_RANGE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = idx_slot;
                end
            end
            default: begin
            end
        endcase
    end

    // ring state and capacity; a capacity write also empties the ring
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_held  <= '0;
            r_cap   <= CNT_W'(CAP_RST);
        end else if (i_cfg_we) begin
            r_front <= '0;
            r_back  <= '0;
            r_held  <= '0;
            r_cap   <= cfg_cap;
        end else if (s_accept) begin
            r_front <= n_front;
            r_back  <= n_back;
            r_held  <= n_held;
        end
    end

    // slot memory write port
    always_ff @(posedge i_clk) begin
        if (s_accept && wr_en) begin
            r_mem[wr_addr] <= req_data;
        end
    end

    // slot memory read port, held while the result waits
    always_ff @(posedge i_clk) begin
        if (s_accept && rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_has_data <= rd_en;
            r_status   <= n_status;
            r_fill     <= n_held;
            r_free     <= r_cap - n_held;
            r_empty    <= (n_held == '0);
            r_full     <= (n_held >= r_cap);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = OUT_TDATA_W'({r_full, r_empty, r_free, r_fill,
                                         (r_has_data ? r_rd_data : {DATA_WIDTH{1'b0}})});

    // count never passes the capacity
    a_held_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= r_cap)
        else $error("held count above capacity");

    // capacity stays within 1..DEPTH
    a_cap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cap != '0) && (32'(r_cap) <= 32'(DEPTH)))
        else $error("capacity out of range");

    // an accepted clear request reports an empty ring
    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && !i_cfg_we && (s_axis_tuser == REQ_CLEAR)
        |=> (r_fill == '0) && r_empty && (r_status == ST_OK))
        else $error("clear did not empty the ring");

    // a push back that fits grows the count by one
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && !i_cfg_we && (s_axis_tuser == REQ_PUSH_BACK) && !ring_full
        |=> r_held == $past(r_held) + CNT_W'(1))
        else $error("push back did not grow the count");

    // pointers agree with the count once wrapped at the capacity
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (((ADD_W'(r_front) + ADD_W'(r_held)) == ADD_W'(r_back))
        || ((ADD_W'(r_front) + ADD_W'(r_held)) == ADD_W'(r_back) + ADD_W'(r_cap))))
        else $error("pointers disagree with count");

endmodule
